[hw/rtl/vmf_pkg.sv]
// Package for the volume median filter.
// Holds sizes, register indexes, opcodes and payload widths.
// No dependencies.
package vmf_pkg;
    localparam int MAX_DIM    = 64;
    localparam int MAX_WIN    = 7;
    localparam int POS_W      = $clog2(MAX_DIM);
    localparam int DIM_W      = POS_W + 1;
    localparam int WIN_W      = $clog2(MAX_WIN + 1);
    localparam int VOL_DEPTH  = MAX_DIM * MAX_DIM * MAX_DIM;
    localparam int VOL_AW     = 3 * POS_W;
    localparam int GBUF_DEPTH = MAX_WIN * MAX_WIN * MAX_WIN;
    localparam int GBUF_AW    = $clog2(GBUF_DEPTH);
    localparam int CNT_W      = $clog2(GBUF_DEPTH + 1);
    localparam int DATA_W     = 32;
    localparam int PADDR_W    = 5;
    localparam int COORD_W    = POS_W + 2;

    localparam logic [2:0] REG_DIM_X = 3'd0;
    localparam logic [2:0] REG_DIM_Y = 3'd1;
    localparam logic [2:0] REG_DIM_Z = 3'd2;
    localparam logic [2:0] REG_WIN_X = 3'd3;
    localparam logic [2:0] REG_WIN_Y = 3'd4;
    localparam logic [2:0] REG_WIN_Z = 3'd5;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;
endpackage

[hw/rtl/vmf_if.sv]
// Channel interfaces for the volume median filter.
// Depends on vmf_pkg.
interface vmf_in_if;
    logic                                valid;
    logic                                ready;
    logic                                opcode;
    logic [vmf_pkg::POS_W-1:0]           pos_x;
    logic [vmf_pkg::POS_W-1:0]           pos_y;
    logic [vmf_pkg::POS_W-1:0]           pos_z;
    logic signed [vmf_pkg::DATA_W-1:0]   sample;
    modport source (output valid, opcode, pos_x, pos_y, pos_z, sample, input ready);
    modport sink   (input valid, opcode, pos_x, pos_y, pos_z, sample, output ready);
endinterface

interface vmf_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [vmf_pkg::DATA_W-1:0]   median_value;
    logic [vmf_pkg::CNT_W-1:0]           neighbour_count;
    logic                                coord_error;
    modport source (output valid, median_value, neighbour_count, coord_error, input ready);
    modport sink   (input valid, median_value, neighbour_count, coord_error, output ready);
endinterface

[hw/rtl/volume_median_filter.sv]
// Top level of the volume median filter: register port, volume store,
// gather buffer and the rank-select sequencer. Depends on vmf_pkg, vmf_if.
//
//   channel | dir | handshake         | payload
//   req     | in  | valid/ready       | opcode, pos_x/y/z, sample
//   rsp     | out | valid/ready       | median_value, neighbour_count, coord_error
//   apb     | in  | psel/penable      | paddr, pwdata, prdata
//
// A load is written to the volume store when it is accepted. A query checks
// each window position and writes each in-volume neighbour to the gather
// buffer, then for each candidate tried compares it against every neighbour,
// then hands over the result. A position error goes straight to hand-over.
// Candidates and neighbours are read through the one gather buffer read port.
// Reset clears control and the config registers; the memories need no clearing.
// A result held in the output register does not block loads; one still waiting in ST_DONE blocks all requests.
module volume_median_filter (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [vmf_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    vmf_in_if.sink                        req,
    vmf_out_if.source                     rsp
);
    import vmf_pkg::*;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_GCHK = 4'd1;
    localparam logic [3:0] ST_GWR  = 4'd2;
    localparam logic [3:0] ST_CRD  = 4'd3;
    localparam logic [3:0] ST_CLAT = 4'd4;
    localparam logic [3:0] ST_JRD  = 4'd5;
    localparam logic [3:0] ST_JCMP = 4'd6;
    localparam logic [3:0] ST_CHK  = 4'd7;
    localparam logic [3:0] ST_DONE = 4'd8;

    logic [DIM_W-1:0] dim_x_reg, dim_y_reg, dim_z_reg;
    logic [WIN_W-1:0] win_x_reg, win_y_reg, win_z_reg;

    logic [3:0]         state_reg, state_next;
    logic [POS_W-1:0]   px_reg, px_next, py_reg, py_next, pz_reg, pz_next;
    logic [WIN_W-1:0]   wx_reg, wx_next, wy_reg, wy_next, wz_reg, wz_next;
    logic [WIN_W-1:0]   ix_reg, ix_next, iy_reg, iy_next, iz_reg, iz_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [CNT_W-1:0]   ci_reg, ci_next, j_reg, j_next;
    logic [CNT_W-1:0]   lt_reg, lt_next, le_reg, le_next;
    logic [DATA_W-1:0]  cand_reg, cand_next;
    logic               ovalid_reg, ovalid_next;
    logic [DATA_W-1:0]  omed_reg, omed_next, res_med_reg, res_med_next;
    logic [CNT_W-1:0]   ocnt_reg, ocnt_next, res_cnt_reg, res_cnt_next;
    logic               oerr_reg, oerr_next, res_err_reg, res_err_next;

    logic [DATA_W-1:0]  vol_mem [VOL_DEPTH];
    logic [DATA_W-1:0]  gbuf_mem [GBUF_DEPTH];
    logic [DATA_W-1:0]  vol_rd_reg, gbuf_rd_reg;

    logic [DIM_W-1:0]   dx, dy, dz;
    logic [COORD_W-1:0] cx, cy, cz;
    logic               in_range, win_last, req_acc, load_acc, cfg_wr;
    logic [VOL_AW-1:0]  vol_raddr;
    logic [GBUF_AW-1:0] gbuf_raddr;
    logic [CNT_W-1:0]   rank;

    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] d);
        logic [DIM_W-1:0] r;
        r = d;
        if (d == '0)
            r = DIM_W'(1);
        else if (d > DIM_W'(MAX_DIM))
            r = DIM_W'(MAX_DIM);
        return r;
    endfunction

    function automatic logic [WIN_W-1:0] eff_win(input logic [WIN_W-1:0] w,
                                                 input logic [DIM_W-1:0] d);
        logic [WIN_W-1:0] r;
        r = (w == '0) ? WIN_W'(1) : w;
        if (r > WIN_W'(MAX_WIN))
            r = WIN_W'(MAX_WIN);
        if (DIM_W'(r) > d)
            r = d[WIN_W-1:0];
        return r;
    endfunction

    function automatic logic [COORD_W-1:0] coord(input logic [POS_W-1:0] p,
                                                 input logic [WIN_W-1:0] w,
                                                 input logic [WIN_W-1:0] i);
        return COORD_W'(p) - COORD_W'(w >> 1) + COORD_W'(i);
    endfunction

    assign dx = eff_dim(dim_x_reg);
    assign dy = eff_dim(dim_y_reg);
    assign dz = eff_dim(dim_z_reg);

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        unique case (paddr[PADDR_W-1:2])
            REG_DIM_X: prdata = 32'(dim_x_reg);
            REG_DIM_Y: prdata = 32'(dim_y_reg);
            REG_DIM_Z: prdata = 32'(dim_z_reg);
            REG_WIN_X: prdata = 32'(win_x_reg);
            REG_WIN_Y: prdata = 32'(win_y_reg);
            REG_WIN_Z: prdata = 32'(win_z_reg);
            default:   prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_x_reg <= DIM_W'(MAX_DIM);
            dim_y_reg <= DIM_W'(MAX_DIM);
            dim_z_reg <= DIM_W'(MAX_DIM);
            win_x_reg <= WIN_W'(3);
            win_y_reg <= WIN_W'(3);
            win_z_reg <= WIN_W'(3);
        end
        else if (cfg_wr)
        begin
            unique case (paddr[PADDR_W-1:2])
                REG_DIM_X: dim_x_reg <= pwdata[DIM_W-1:0];
                REG_DIM_Y: dim_y_reg <= pwdata[DIM_W-1:0];
                REG_DIM_Z: dim_z_reg <= pwdata[DIM_W-1:0];
                REG_WIN_X: win_x_reg <= pwdata[WIN_W-1:0];
                REG_WIN_Y: win_y_reg <= pwdata[WIN_W-1:0];
                REG_WIN_Z: win_z_reg <= pwdata[WIN_W-1:0];
                default:   ;
            endcase
        end
    end

    assign req.ready = (state_reg == ST_IDLE);
    assign req_acc   = req.valid && req.ready;
    assign load_acc  = req_acc && (req.opcode == OP_LOAD);

    assign cx = coord(px_reg, wx_reg, ix_reg);
    assign cy = coord(py_reg, wy_reg, iy_reg);
    assign cz = coord(pz_reg, wz_reg, iz_reg);
    assign in_range = !cx[COORD_W-1] && (cx < COORD_W'(dx))
                   && !cy[COORD_W-1] && (cy < COORD_W'(dy))
                   && !cz[COORD_W-1] && (cz < COORD_W'(dz));
    assign win_last = (ix_reg == wx_reg - WIN_W'(1)) && (iy_reg == wy_reg - WIN_W'(1))
                   && (iz_reg == wz_reg - WIN_W'(1));
    assign vol_raddr  = {cz[POS_W-1:0], cy[POS_W-1:0], cx[POS_W-1:0]};
    assign gbuf_raddr = (state_reg == ST_CRD) ? ci_reg[GBUF_AW-1:0] : j_reg[GBUF_AW-1:0];
    assign rank = cnt_reg >> 1;

    always_ff @(posedge clk)
    begin
        if (load_acc)
            vol_mem[{req.pos_z, req.pos_y, req.pos_x}] <= req.sample;
        vol_rd_reg <= vol_mem[vol_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_GWR)
            gbuf_mem[cnt_reg[GBUF_AW-1:0]] <= vol_rd_reg;
        gbuf_rd_reg <= gbuf_mem[gbuf_raddr];
    end

    always_comb
    begin
        state_next   = state_reg;
        px_next      = px_reg;
        py_next      = py_reg;
        pz_next      = pz_reg;
        wx_next      = wx_reg;
        wy_next      = wy_reg;
        wz_next      = wz_reg;
        ix_next      = ix_reg;
        iy_next      = iy_reg;
        iz_next      = iz_reg;
        cnt_next     = cnt_reg;
        ci_next      = ci_reg;
        j_next       = j_reg;
        lt_next      = lt_reg;
        le_next      = le_reg;
        cand_next    = cand_reg;
        res_med_next = res_med_reg;
        res_cnt_next = res_cnt_reg;
        res_err_next = res_err_reg;
        ovalid_next  = ovalid_reg && !rsp.ready;
        omed_next    = omed_reg;
        ocnt_next    = ocnt_reg;
        oerr_next    = oerr_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_acc && (req.opcode == OP_QUERY))
                begin
                    px_next  = req.pos_x;
                    py_next  = req.pos_y;
                    pz_next  = req.pos_z;
                    wx_next  = eff_win(win_x_reg, dx);
                    wy_next  = eff_win(win_y_reg, dy);
                    wz_next  = eff_win(win_z_reg, dz);
                    ix_next  = '0;
                    iy_next  = '0;
                    iz_next  = '0;
                    cnt_next = '0;
                    if ((DIM_W'(req.pos_x) >= dx) || (DIM_W'(req.pos_y) >= dy)
                        || (DIM_W'(req.pos_z) >= dz))
                    begin
                        res_med_next = '0;
                        res_cnt_next = '0;
                        res_err_next = 1'b1;
                        state_next   = ST_DONE;
                    end
                    else
                        state_next = ST_GCHK;
                end
            end
            ST_GCHK, ST_GWR:
            begin
                if (state_reg == ST_GWR)
                    cnt_next = cnt_reg + CNT_W'(1);
                if ((state_reg == ST_GCHK) && in_range)
                    state_next = ST_GWR;
                else
                begin
                    state_next = ST_GCHK;
                    if (win_last)
                    begin
                        ci_next    = '0;
                        state_next = ST_CRD;
                    end
                    else if (ix_reg != wx_reg - WIN_W'(1))
                        ix_next = ix_reg + WIN_W'(1);
                    else
                    begin
                        ix_next = '0;
                        if (iy_reg != wy_reg - WIN_W'(1))
                            iy_next = iy_reg + WIN_W'(1);
                        else
                        begin
                            iy_next = '0;
                            iz_next = iz_reg + WIN_W'(1);
                        end
                    end
                end
            end
            ST_CRD:
                state_next = ST_CLAT;
            ST_CLAT:
            begin
                cand_next  = gbuf_rd_reg;
                j_next     = '0;
                lt_next    = '0;
                le_next    = '0;
                state_next = ST_JRD;
            end
            ST_JRD:
                state_next = ST_JCMP;
            ST_JCMP:
            begin
                if ($signed(gbuf_rd_reg) < $signed(cand_reg))
                    lt_next = lt_reg + CNT_W'(1);
                if ($signed(gbuf_rd_reg) <= $signed(cand_reg))
                    le_next = le_reg + CNT_W'(1);
                j_next = j_reg + CNT_W'(1);
                if (j_reg == cnt_reg - CNT_W'(1))
                    state_next = ST_CHK;
                else
                    state_next = ST_JRD;
            end
            ST_CHK:
            begin
                if ((lt_reg <= rank) && (rank < le_reg))
                begin
                    res_med_next = cand_reg;
                    res_cnt_next = cnt_reg;
                    res_err_next = 1'b0;
                    state_next   = ST_DONE;
                end
                else
                begin
                    ci_next    = ci_reg + CNT_W'(1);
                    state_next = ST_CRD;
                end
            end
            ST_DONE:
            begin
                if (!ovalid_reg || rsp.ready)
                begin
                    ovalid_next = 1'b1;
                    omed_next   = res_med_reg;
                    ocnt_next   = res_cnt_reg;
                    oerr_next   = res_err_reg;
                    state_next  = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg      <= px_next;
        py_reg      <= py_next;
        pz_reg      <= pz_next;
        wx_reg      <= wx_next;
        wy_reg      <= wy_next;
        wz_reg      <= wz_next;
        ix_reg      <= ix_next;
        iy_reg      <= iy_next;
        iz_reg      <= iz_next;
        cnt_reg     <= cnt_next;
        ci_reg      <= ci_next;
        j_reg       <= j_next;
        lt_reg      <= lt_next;
        le_reg      <= le_next;
        cand_reg    <= cand_next;
        res_med_reg <= res_med_next;
        res_cnt_reg <= res_cnt_next;
        res_err_reg <= res_err_next;
        omed_reg    <= omed_next;
        ocnt_reg    <= ocnt_next;
        oerr_reg    <= oerr_next;
    end

    assign rsp.valid           = ovalid_reg;
    assign rsp.median_value    = omed_reg;
    assign rsp.neighbour_count = ocnt_reg;
    assign rsp.coord_error     = oerr_reg;
endmodule

[hw/rtl/vmf_checker.sv]
// Port-level checks for the volume median filter, bound to the top level.
// Depends on vmf_pkg.
module vmf_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          req_valid,
    input logic                          req_ready,
    input logic                          req_opcode,
    input logic                          rsp_valid,
    input logic                          rsp_ready,
    input logic [vmf_pkg::DATA_W-1:0]    rsp_median_value,
    input logic [vmf_pkg::CNT_W-1:0]     rsp_neighbour_count,
    input logic                          rsp_coord_error
);
    import vmf_pkg::*;

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("rsp transaction dropped while stalled");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_coord_error |-> (rsp_neighbour_count == '0)
            && (rsp_median_value == '0))
        else $error("error result carries data");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_coord_error |-> (rsp_neighbour_count != '0)
            && (rsp_neighbour_count <= CNT_W'(GBUF_DEPTH)))
        else $error("neighbour count out of range");

    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req_opcode == OP_QUERY) |=> !req_ready)
        else $error("ready held during query");
endmodule

bind volume_median_filter vmf_checker u_vmf_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .req_valid           (req.valid),
    .req_ready           (req.ready),
    .req_opcode          (req.opcode),
    .rsp_valid           (rsp.valid),
    .rsp_ready           (rsp.ready),
    .rsp_median_value    (rsp.median_value),
    .rsp_neighbour_count (rsp.neighbour_count),
    .rsp_coord_error     (rsp.coord_error)
);
